// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of this block.
// Every use samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, prop, msg)

`define ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/auhlc_pkg.sv =====
`timescale 1ns / 1ps

package auhlc_pkg;

  localparam int unsigned HdrBytes        = 24;
  localparam int unsigned EncMax          = 27;
  localparam int unsigned DivSteps        = 42;
  localparam int unsigned DefaultQueueDepth = 2;

  localparam logic [31:0] Magic       = 32'h2e73_6e64;
  localparam logic [31:0] NoSize      = 32'hffff_ffff;
  localparam logic [31:0] DefaultRate = 32'd8000;
  localparam logic [9:0]  MsPerS      = 10'd1000;

  typedef enum logic [1:0] {
    StatusParsed    = 2'd0,
    StatusDefault   = 2'd1,
    StatusBadOffset = 2'd2
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] rate;
    logic [31:0] nbytes;
    logic [7:0]  bpf;
  } job_t;

  // Bytes per sample for each encoding code.
  function automatic logic [3:0] enc_bytes(input logic [4:0] enc);
    logic [3:0] b;
    case (enc)
      5'd1, 5'd2, 5'd27: b = 4'd1;
      5'd3:              b = 4'd2;
      5'd4:              b = 4'd3;
      5'd5, 5'd6:        b = 4'd4;
      5'd7:              b = 4'd8;
      default:           b = 4'd0;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/auhlc_front.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module auhlc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  output logic               job_valid_o,
  input  logic               job_ready_i,
  output auhlc_pkg::job_t    job_o
);

  logic [4:0]  cnt_q, cnt_d;
  logic        pending_q, pending_d;
  logic        full_q, full_d;
  logic [31:0] file_size_q;
  logic [7:0]  hdr_q [auhlc_pkg::HdrBytes];
  logic        accept;

  logic [31:0] magic, off, size, enc, rate, chan;
  logic        bad_off;
  logic [3:0]  tab;
  logic [11:0] bpf_full;

  assign ready_o     = !pending_q;
  assign accept      = valid_i && ready_o;
  assign job_valid_o = pending_q;

  always_comb begin
    cnt_d     = cnt_q;
    pending_d = pending_q;
    full_d    = full_q;
    if (accept) begin
      if (cnt_q < 5'(auhlc_pkg::HdrBytes)) begin
        cnt_d = cnt_q + 5'd1;
      end
      if (last_i) begin
        cnt_d     = '0;
        pending_d = 1'b1;
        full_d    = (cnt_q >= 5'(auhlc_pkg::HdrBytes - 1));
      end
    end
    if (pending_q && job_ready_i) begin
      pending_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pending_q   <= 1'b0;
      full_q      <= 1'b0;
      file_size_q <= '0;
    end else begin
      cnt_q     <= cnt_d;
      pending_q <= pending_d;
      full_q    <= full_d;
      if (cfg_valid_i) begin
        file_size_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (cnt_q < 5'(auhlc_pkg::HdrBytes))) begin
      hdr_q[cnt_q] <= byte_i;
    end
  end

  assign magic = {hdr_q[0],  hdr_q[1],  hdr_q[2],  hdr_q[3]};
  assign off   = {hdr_q[4],  hdr_q[5],  hdr_q[6],  hdr_q[7]};
  assign size  = {hdr_q[8],  hdr_q[9],  hdr_q[10], hdr_q[11]};
  assign enc   = {hdr_q[12], hdr_q[13], hdr_q[14], hdr_q[15]};
  assign rate  = {hdr_q[16], hdr_q[17], hdr_q[18], hdr_q[19]};
  assign chan  = {hdr_q[20], hdr_q[21], hdr_q[22], hdr_q[23]};

  assign bad_off  = off[31] || (off < 32'(auhlc_pkg::HdrBytes));
  assign tab      = (enc > 32'(auhlc_pkg::EncMax)) ? 4'd0 : auhlc_pkg::enc_bytes(enc[4:0]);
  assign bpf_full = {8'd0, tab} * {4'd0, chan[7:0]};

  always_comb begin
    if (!full_q || (magic != auhlc_pkg::Magic)) begin
      job_o.status = auhlc_pkg::StatusDefault;
      job_o.rate   = auhlc_pkg::DefaultRate;
      job_o.nbytes = file_size_q;
      job_o.bpf    = 8'd1;
    end else if (bad_off) begin
      job_o.status = auhlc_pkg::StatusBadOffset;
      job_o.rate   = '0;
      job_o.nbytes = '0;
      job_o.bpf    = '0;
    end else begin
      job_o.status = auhlc_pkg::StatusParsed;
      job_o.rate   = rate;
      job_o.nbytes = (size == auhlc_pkg::NoSize) ? (file_size_q - off) : size;
      job_o.bpf    = bpf_full[7:0];
    end
  end

  `ASSERT_NEVER(a_cnt_range, cnt_q > 5'(auhlc_pkg::HdrBytes), "header byte count overran")
  `ASSERT_CLK(a_cnt_clear, pending_q |-> (cnt_q == 5'd0), "count not cleared after last byte")

endmodule

// ===== rtl/auhlc_fifo.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module auhlc_fifo #(
  parameter int unsigned Depth = auhlc_pkg::DefaultQueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  auhlc_pkg::job_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output auhlc_pkg::job_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  auhlc_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `ASSERT_NEVER(a_fifo_count, cnt_q > CntW'(Depth), "queue count beyond depth")

endmodule

// ===== rtl/auhlc_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module auhlc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  auhlc_pkg::job_t job_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      status_o,
  output logic [31:0]     rate_o,
  output logic [31:0]     length_o,
  output logic            fault_o
);

  typedef enum logic [1:0] {
    StIdle,
    StMul,
    StDiv,
    StOut
  } state_e;

  state_e              state_q;
  logic [5:0]          step_q;
  logic [31:0]         nbytes_q;
  logic [7:0]          bpf_q;
  logic [31:0]         divisor_q;
  logic [31:0]         rem_q;
  logic [41:0]         dq_q;
  auhlc_pkg::status_e  status_q;
  logic [31:0]         rate_q;
  logic [31:0]         length_q;
  logic                fault_q;

  logic [41:0] dividend;
  logic [31:0] div_prod;
  logic [32:0] rem_sh;
  logic        ge;

  assign job_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign status_o    = status_q;
  assign rate_o      = rate_q;
  assign length_o    = length_q;
  assign fault_o     = fault_q;

  assign dividend = {10'd0, nbytes_q} * {32'd0, auhlc_pkg::MsPerS};
  assign div_prod = {24'd0, bpf_q} * rate_q;
  assign rem_sh   = {rem_q, dq_q[41]};
  assign ge       = (rem_sh >= {1'b0, divisor_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      step_q    <= '0;
      nbytes_q  <= '0;
      bpf_q     <= '0;
      divisor_q <= '0;
      rem_q     <= '0;
      dq_q      <= '0;
      status_q  <= auhlc_pkg::StatusParsed;
      rate_q    <= '0;
      length_q  <= '0;
      fault_q   <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            status_q <= job_i.status;
            rate_q   <= job_i.rate;
            nbytes_q <= job_i.nbytes;
            bpf_q    <= job_i.bpf;
            if (job_i.status == auhlc_pkg::StatusBadOffset) begin
              length_q <= '0;
              fault_q  <= 1'b0;
              state_q  <= StOut;
            end else begin
              state_q <= StMul;
            end
          end
        end
        StMul: begin
          dq_q      <= dividend;
          divisor_q <= div_prod;
          rem_q     <= '0;
          step_q    <= '0;
          state_q   <= StDiv;
        end
        StDiv: begin
          if (divisor_q == '0) begin
            length_q <= '0;
            fault_q  <= 1'b1;
            state_q  <= StOut;
          end else begin
            rem_q  <= ge ? 32'(rem_sh - {1'b0, divisor_q}) : rem_sh[31:0];
            dq_q   <= {dq_q[40:0], ge};
            step_q <= step_q + 6'd1;
            if (step_q == 6'(auhlc_pkg::DivSteps - 1)) begin
              length_q <= {dq_q[30:0], ge};
              fault_q  <= 1'b0;
              state_q  <= StOut;
            end
          end
        end
        StOut: begin
          if (out_ready_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `ASSERT_CLK(a_rem_below_div, ((state_q == StDiv) && (divisor_q != '0)) |-> (rem_q < divisor_q),
              "divider remainder not below divisor")
  `ASSERT_CLK(a_fault_zero, (out_valid_o && fault_q) |-> (length_q == '0),
              "fault result with nonzero length")

endmodule

// ===== rtl/au_header_length_calc_core.sv =====
`timescale 1ns / 1ps

// Sun audio header length calculator. File bytes are taken one per cycle on the
// slave stream while the front end holds no classified header; the first 24 are
// kept and tlast closes the file. The cycle after the last byte the header is
// classified and queued when the queue has room, and a new file can start once it
// has been queued. A queued header is loaded into the back end, multiplied, divided
// by a one-bit-per-cycle shift-subtract divider and then presented as the result
// until it is taken. A zero divisor skips the divide, and a bad data offset goes
// straight from loading to the result. Up to QueueDepth classified headers wait
// while the divider is busy and one more is held in the front end, which then
// stalls the slave side until the queue has room. The file size register is always
// ready; it is read when a file's last byte is classified, so it must be written
// only between files by the user; the block itself does not enforce this.
module au_header_length_calc_core #(
  parameter int unsigned QueueDepth = auhlc_pkg::DefaultQueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,      // file_size
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,    // [7:0] header_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,    // [31:0] sample_rate, [63:32] length_ms
  output logic [2:0]  m_axis_tuser     // [1:0] status, [2] divide_fault
);

  auhlc_pkg::job_t front_job, back_job;
  logic            front_valid, front_ready, back_valid, back_ready;
  logic [1:0]      status;
  logic [31:0]     rate, length;
  logic            fault;

  assign cfg_ready_o = 1'b1;

  auhlc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .byte_i      (s_axis_tdata),
    .last_i      (s_axis_tlast),
    .job_valid_o (front_valid),
    .job_ready_i (front_ready),
    .job_o       (front_job)
  );

  auhlc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_job),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_job)
  );

  auhlc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (back_valid),
    .job_ready_o (back_ready),
    .job_i       (back_job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .rate_o      (rate),
    .length_o    (length),
    .fault_o     (fault)
  );

  assign m_axis_tdata = {length, rate};
  assign m_axis_tuser = {fault, status};

endmodule

// ===== tb/au_header_length_calc_checker.sv =====
`timescale 1ns / 1ps

module au_header_length_calc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o
);
  import auhlc_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [31:0] rate;
    logic [31:0] length_ms;
    logic        divide_fault;
  } track_info_t;

  logic [31:0] file_size_q;
  logic [7:0]  hdr_bytes [HdrBytes];
  int          hdr_count;
  track_info_t pending_tracks [$];

  function automatic logic [7:0] bytes_per_sample(input logic [31:0] enc);
    logic [7:0] n;
    case (enc)
      32'd1, 32'd2, 32'd27: n = 8'd1;
      32'd3:                n = 8'd2;
      32'd4:                n = 8'd3;
      32'd5, 32'd6:         n = 8'd4;
      32'd7:                n = 8'd8;
      default:              n = 8'd0;
    endcase
    return n;
  endfunction

  function automatic logic [31:0] hdr_word(input int pos);
    return {hdr_bytes[pos], hdr_bytes[pos + 1], hdr_bytes[pos + 2], hdr_bytes[pos + 3]};
  endfunction

  function automatic track_info_t predict_track();
    track_info_t info;
    logic [31:0] offset;
    logic [31:0] nbytes;
    logic [31:0] rate;
    logic [31:0] chans;
    logic [31:0] divisor;
    logic [7:0]  frame_bytes;
    logic [63:0] dividend;
    logic [63:0] quotient;
    info.status = StatusParsed;
    info.rate = '0;
    info.length_ms = '0;
    info.divide_fault = 1'b0;
    if (hdr_count < HdrBytes || hdr_word(0) != Magic) begin
      info.status = StatusDefault;
      rate = DefaultRate;
      nbytes = file_size_q;
      frame_bytes = 8'd1;
    end else begin
      offset = hdr_word(4);
      if (offset[31] || offset < HdrBytes) begin
        info.status = StatusBadOffset;
        return info;
      end
      nbytes = hdr_word(8);
      if (nbytes == NoSize) begin
        nbytes = file_size_q - offset;
      end
      chans = hdr_word(20);
      frame_bytes = bytes_per_sample(hdr_word(12)) * chans[7:0];
      rate = hdr_word(16);
    end
    info.rate = rate;
    divisor = rate * {24'd0, frame_bytes};
    dividend = ({32'd0, nbytes} * 64'd1000) & ((64'd1 << 42) - 64'd1);
    if (divisor == 32'd0) begin
      info.divide_fault = 1'b1;
    end else begin
      quotient = dividend / {32'd0, divisor};
      info.length_ms = quotient[31:0];
    end
    return info;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    track_info_t want;
    track_info_t got;
    if (!rst_ni) begin
      file_size_q = '0;
      hdr_count = 0;
      pending_tracks.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        file_size_q = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (hdr_count < HdrBytes) begin
          hdr_bytes[hdr_count] = s_axis_tdata;
          hdr_count++;
        end
        if (s_axis_tlast) begin
          pending_tracks.push_back(predict_track());
          hdr_count = 0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = status_e'(m_axis_tuser[1:0]);
        got.divide_fault = m_axis_tuser[2];
        got.rate = m_axis_tdata[31:0];
        got.length_ms = m_axis_tdata[63:32];
        if (pending_tracks.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d rate %0d",
                   $time, got.status, got.rate);
          fail_count_o++;
        end else begin
          want = pending_tracks.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fail_count_o++;
          end
          if (got.rate != want.rate) begin
            $display("%0t: sample_rate expected %0d actual %0d", $time, want.rate, got.rate);
            fail_count_o++;
          end
          if (got.length_ms != want.length_ms) begin
            $display("%0t: length_ms expected %0d actual %0d",
                     $time, want.length_ms, got.length_ms);
            fail_count_o++;
          end
          if (got.divide_fault != want.divide_fault) begin
            $display("%0t: divide_fault expected %0d actual %0d",
                     $time, want.divide_fault, got.divide_fault);
            fail_count_o++;
          end
        end
      end
      pending_o = pending_tracks.size();
    end
  end

endmodule

// ===== tb/tb_au_header_length_calc_core.sv =====
`timescale 1ns / 1ps

module tb_au_header_length_calc_core;
  import auhlc_pkg::*;

  localparam int CycleLimit = 300000;
  localparam int HoldCycles = 600;
  localparam int DrainCycles = 60;
  localparam int PhaseBytes = 215;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;

  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  logic [7:0]  file_bytes [$];

  au_header_length_calc_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  au_header_length_calc_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // The receiver normally stalls at random; once it holds off for a long stretch so that
  // the result queue backs up into the byte stream.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        hold_done = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 7);
      end
    end
  end

  task automatic send_byte(input logic [7:0] value, input logic is_last);
    while (!steady && $urandom_range(99) < 7) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= value;
    s_axis_tlast <= is_last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_file();
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
    file_bytes.delete();
  endtask

  task automatic put_word(input logic [31:0] w);
    file_bytes.push_back(w[31:24]);
    file_bytes.push_back(w[23:16]);
    file_bytes.push_back(w[15:8]);
    file_bytes.push_back(w[7:0]);
  endtask

  task automatic write_file_size(input logic [31:0] value);
    while (pending_count != 0) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed headers with random content; the rest are bad offsets, broken
  // magic, truncated headers and plain noise.
  task automatic make_random_file();
    int kind;
    int keep;
    logic [31:0] offset;
    logic [31:0] size;
    logic [31:0] enc;
    logic [31:0] rate;
    logic [31:0] chans;
    kind = $urandom_range(99);
    file_bytes.delete();
    if (kind < 8) begin
      repeat ($urandom_range(1, 40)) file_bytes.push_back(8'($urandom));
      return;
    end
    case ($urandom_range(7))
      0: offset = 32'd24;
      1: offset = 32'h7fff_ffff;
      2: offset = $urandom_range(25, 40);
      default: offset = $urandom_range(24, 4096);
    endcase
    if (kind < 18) begin
      case ($urandom_range(5))
        0: offset = 32'd23;
        1: offset = 32'd0;
        2: offset = 32'h8000_0000;
        3: offset = 32'hffff_ffff;
        4: offset = $urandom | 32'h8000_0000;
        default: offset = $urandom_range(0, 23);
      endcase
    end
    case ($urandom_range(7))
      0, 1: size = NoSize;
      2: size = 32'd0;
      3: size = 32'hffff_fffe;
      4: size = $urandom;
      default: size = $urandom_range(0, 1 << 22);
    endcase
    case ($urandom_range(9))
      0: enc = 32'd28;
      1: enc = $urandom;
      default: enc = $urandom_range(0, EncMax);
    endcase
    case ($urandom_range(9))
      0: rate = 32'd0;
      1: rate = 32'hffff_ffff;
      2: rate = $urandom;
      default: rate = $urandom_range(1, 192000);
    endcase
    case ($urandom_range(9))
      0: chans = 32'd0;
      1: chans = 32'd256;
      2: chans = $urandom;
      default: chans = $urandom_range(1, 8);
    endcase
    put_word(Magic);
    put_word(offset);
    put_word(size);
    put_word(enc);
    put_word(rate);
    put_word(chans);
    if (kind < 28 && kind >= 18) begin
      keep = $urandom_range(3);
      file_bytes[keep] = file_bytes[keep] ^ 8'($urandom_range(1, 255));
    end else if (kind < 38 && kind >= 28) begin
      keep = $urandom_range(1, HdrBytes - 1);
      repeat (HdrBytes - keep) void'(file_bytes.pop_back());
    end else if ($urandom_range(2) == 0) begin
      repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
    end
  endtask

  initial begin
    logic [31:0] phase_size [6];
    int phase_start;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    phase_size[0] = 32'hffff_ffff;
    phase_size[1] = 32'd0;
    phase_size[2] = $urandom;
    phase_size[3] = 32'd24;
    phase_size[4] = $urandom_range(1000, 1 << 24);
    phase_size[5] = $urandom;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_file_size(32'd50000);
    file_bytes.push_back(8'h2e);
    send_file();
    put_word(Magic);
    put_word(32'd24);
    put_word(NoSize);
    put_word(32'd3);
    put_word(32'd44100);
    put_word(32'd2);
    send_file();
    s_axis_tvalid <= 1'b0;

    for (int phase = 0; phase < 6; phase++) begin
      write_file_size(phase_size[phase]);
      steady = (phase == 3);
      if (phase == 2) begin
        hold_req = 1'b1;
        repeat (40) begin
          repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
          send_file();
        end
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        make_random_file();
        send_file();
      end
      s_axis_tvalid <= 1'b0;
    end
    steady = 1'b0;

    while (pending_count != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
